[rtl/rdsm_pkg.sv]
// Shared types and constants for the dot-star pattern matcher.
// No dependencies; imported by rdsm_token_mem and regex_dot_star_matcher.
`default_nettype none

package rdsm_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd3;

  localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h2E;

  // One stored pattern token: its byte and whether a star follows it.
  typedef struct packed {
    logic              starred;
    logic [CHAR_W-1:0] tok_byte;
  } tok_t;

endpackage

`default_nettype wire

[rtl/rdsm_token_mem.sv]
// Token store for the matcher: one write port, one registered read port.
// Depends on rdsm_pkg for the token entry type.
`default_nettype none

module rdsm_token_mem
  import rdsm_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire tok_t          wr_data,
  input  wire logic          rd_en,
  input  wire logic [IW-1:0] rd_addr,
  output tok_t               rd_data
);

  tok_t mem [DEPTH];
  tok_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/regex_dot_star_matcher.sv]
// Whole-string matcher for patterns of literal bytes, '.' and postfix '*'.
// Every item (any command) goes from acceptance to its result through a sweep
// that visits one row entry per cycle through a single match cell fed by the
// one read port of the token store. A new item is taken only once the last one
// has put its result into the output register; a new item may be taken while the
// previous result still waits in the output register. Reset (rst_n, sync) empties
// the pattern, clears the overflow flag and sets the row to bit zero.
`default_nettype none

module regex_dot_star_matcher
  import rdsm_pkg::*;
#(
  parameter int MAX_TOKENS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  in_cmd,
  input  wire logic [CHAR_W-1:0] in_char_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_whole_match,
  output logic                   out_pattern_overflow
);

  // Row has one entry per token plus the empty-prefix entry.
  localparam int ROW_N = MAX_TOKENS + 1;
  // Step counter and token count both range over 0..MAX_TOKENS.
  localparam int SW = $clog2(MAX_TOKENS + 1);
  localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam logic [SW-1:0] LAST_STEP = SW'(MAX_TOKENS);

  logic [1:0]        state_r, state_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [SW-1:0]     total_r, total_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ROW_N-1:0]  row_r, row_nxt;
  logic              prev_old_r, prev_old_nxt;
  logic              prev_new_r, prev_new_nxt;
  logic              match_r, match_nxt;
  logic              text_mode_r, text_mode_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic [CHAR_W-1:0] last_byte_r, last_byte_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_match_r, out_match_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic          accept;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  tok_t          wr_data;
  logic          rd_en;
  tok_t          rd_tok;

  logic          b_old;
  logic          hit;
  logic          new_bit;
  logic          out_free;

  // The token store holds each token's byte and its star mark together.
  // A star rewrites the newest entry with its byte kept in last_byte_r, so
  // no read-modify-write of the store is needed.
  rdsm_token_mem #(
    .DEPTH (MAX_TOKENS),
    .IW    (IW)
  ) u_tok_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (step_r[IW-1:0]),
    .rd_data (rd_tok)
  );

  assign in_ready             = (state_r == ST_IDLE);
  assign accept               = in_valid && in_ready;
  assign out_valid            = out_valid_r;
  assign out_whole_match      = out_match_r;
  assign out_pattern_overflow = out_ovf_r;
  assign out_free             = !out_valid_r || out_ready;

  // During the sweep, the entry that step j reads was addressed at step j-1.
  assign rd_en = (state_r == ST_RUN) && (step_r < LAST_STEP);

  // Pattern writes happen at acceptance, before any sweep read.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = total_r[IW-1:0];
    wr_data = '{starred: 1'b0, tok_byte: in_char_value};
    if (accept && (in_cmd == CMD_PATTERN)) begin
      if (in_char_value == STAR_BYTE) begin
        if ((total_r != '0) && !ovf_r) begin
          wr_en   = 1'b1;
          wr_addr = IW'(total_r - SW'(1));
          wr_data = '{starred: 1'b1, tok_byte: last_byte_r};
        end
      end else if (total_r < LAST_STEP) begin
        wr_en = 1'b1;
      end
    end
  end

  // The shared match cell. The row rotates right once per step, so the old
  // value of entry j always sits in bit zero when step j runs, and the new
  // value enters at the top. Once the sweep has visited every entry the row is back in order.
  assign b_old = row_r[0];
  assign hit   = (rd_tok.tok_byte == char_r) || (rd_tok.tok_byte == ANY_BYTE);

  always_comb begin
    if (step_r == '0) begin
      // Empty-prefix entry: only the empty text matches it.
      new_bit = !text_mode_r;
    end else if (step_r <= total_r) begin
      if (text_mode_r) begin
        new_bit = rd_tok.starred ? (prev_new_r || (hit && b_old))
                                 : (prev_old_r && hit);
      end else begin
        new_bit = prev_new_r && rd_tok.starred;
      end
    end else begin
      // Entries past the pattern: text bytes leave them, every other command clears them.
      new_bit = text_mode_r ? b_old : 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    row_nxt       = row_r;
    prev_old_nxt  = prev_old_r;
    prev_new_nxt  = prev_new_r;
    match_nxt     = match_r;
    text_mode_nxt = text_mode_r;
    char_nxt      = char_r;
    last_byte_nxt = last_byte_r;
    out_valid_nxt = out_valid_r;
    out_match_nxt = out_match_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt     = ST_RUN;
          step_nxt      = '0;
          char_nxt      = in_char_value;
          text_mode_nxt = (in_cmd == CMD_TEXT);
          unique case (in_cmd)
            CMD_CLEAR: begin
              total_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            CMD_PATTERN: begin
              if (in_char_value != STAR_BYTE) begin
                if (total_r < LAST_STEP) begin
                  total_nxt     = total_r + SW'(1);
                  last_byte_nxt = in_char_value;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            CMD_RESTART, CMD_TEXT: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        row_nxt      = {new_bit, row_r[ROW_N-1:1]};
        prev_old_nxt = b_old;
        prev_new_nxt = new_bit;
        if (step_r == total_r) begin
          match_nxt = new_bit;
        end
        if (step_r == LAST_STEP) begin
          if (out_free) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_match_nxt = (step_r == total_r) ? new_bit : match_r;
            out_ovf_nxt   = ovf_r;
          end else begin
            state_nxt = ST_HOLD;
          end
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_match_nxt = match_r;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      row_r       <= ROW_N'(1);
      prev_old_r  <= 1'b0;
      prev_new_r  <= 1'b0;
      match_r     <= 1'b0;
      text_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      row_r       <= row_nxt;
      prev_old_r  <= prev_old_nxt;
      prev_new_r  <= prev_new_nxt;
      match_r     <= match_nxt;
      text_mode_r <= text_mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    last_byte_r <= last_byte_nxt;
    out_match_r <= out_match_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

`default_nettype wire
